// ===== rtl/dam_pkg.sv =====
`timescale 1ns / 1ps

package dam_pkg;

  // Command codes carried in the mode field
  localparam logic [2:0] MODE_NONE  = 3'd0;
  localparam logic [2:0] MODE_HOME  = 3'd1;
  localparam logic [2:0] MODE_GOTO  = 3'd2;
  localparam logic [2:0] MODE_ABORT = 3'd3;
  localparam logic [2:0] MODE_CLOSE = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_TURN_TICKS     = 3'd0;
  localparam logic [2:0] REG_PARK_POSITION  = 3'd1;
  localparam logic [2:0] REG_PARK_ON_CLOSE  = 3'd2;
  localparam logic [2:0] REG_SLOW_RANGE     = 3'd3;
  localparam logic [2:0] REG_STOP_TOLERANCE = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_MS     = 3'd5;
  localparam logic [2:0] REG_HOME_POS       = 3'd6;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 32;

  // Configuration reset values
  localparam logic [15:0] RST_TURN_TICKS     = 16'd360;
  localparam logic [15:0] RST_PARK_POSITION  = 16'd0;
  localparam logic        RST_PARK_ON_CLOSE  = 1'b0;
  localparam logic [15:0] RST_SLOW_RANGE     = 16'd20;
  localparam logic [15:0] RST_STOP_TOLERANCE = 16'd2;
  localparam logic [31:0] RST_TIMEOUT_MS     = 32'd60000;
  localparam logic [15:0] RST_HOME_POS       = 16'd0;

  // Direction codes
  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  // Status codes
  localparam logic [1:0] STAT_IDLE  = 2'd0;
  localparam logic [1:0] STAT_ERROR = 2'd1;
  localparam logic [1:0] STAT_CW    = 2'd2;
  localparam logic [1:0] STAT_CCW   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_FAULT    = 3'd1,
    ST_SEEK     = 3'd2,
    ST_SLEW     = 3'd3,
    ST_APPROACH = 3'd4
  } fsm_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_HOME  = 2'd1,
    EV_GOTO  = 2'd2,
    EV_ABORT = 2'd3
  } event_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        goto_dir;
    logic [15:0] goto_target;
    logic [15:0] position;
    logic        home_seen;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       drive_cw;
    logic       drive_ccw;
    logic       motor_slow;
    logic       close_request;
    logic [1:0] dome_status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] turn_ticks;
    logic [15:0] park_position;
    logic        park_on_close;
    logic [15:0] slow_range;
    logic [15:0] stop_tolerance;
    logic [31:0] timeout_ms;
    logic [15:0] home_pos;
  } cfg_t;

  // Drive levels: bit 0 clockwise, bit 1 counterclockwise, bit 2 slow
  function automatic logic [2:0] drive_code(input logic dir, input logic slow);
    drive_code = {slow, dir == DIR_CCW, dir == DIR_CW};
  endfunction

  // Shortest distance around the ring, wrapping modulo turn
  function automatic logic [15:0] ring_dist(input logic [15:0] cur,
                                            input logic [15:0] tgt,
                                            input logic [15:0] turn);
    logic [15:0] diff;
    logic [15:0] half;
    diff = (tgt > cur) ? (tgt - cur) : (cur - tgt);
    half = turn >> 1;
    ring_dist = (diff > half) ? (turn - diff) : diff;
  endfunction

endpackage

// ===== rtl/dome_azimuth_motion_controller.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_data   (in_item_t)
// out      output     out_valid / out_ready  out_data  (out_item_t)
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is held in the input register and is then processed into the result
// register, one item per cycle while the result is not stalled.
// The state update runs in the same cycle as the result, so the next item
// always sees the state left by the one before it.
// rst (synchronous) clears both pipeline valid bits, the motion state and the
// configuration. A stalled result holds the pipeline; cfg is always ready.

module dome_azimuth_motion_controller
  import dam_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  cfg_t      cfg;
  in_item_t  hold_item;
  logic      hold_valid;
  logic      advance;
  out_item_t step_result;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && (!out_valid || out_ready);
  assign in_ready  = !hold_valid || advance;

  dam_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dam_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (hold_item),
    .cfg    (cfg),
    .result (step_result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule

// ===== rtl/dam_cfg.sv =====
`timescale 1ns / 1ps

module dam_cfg
  import dam_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [CfgIndexWidth-1:0] wr_index,
  input  logic [CfgDataWidth-1:0]  wr_data,
  output cfg_t                     cfg
);

  // Write one register per item; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turn_ticks     <= RST_TURN_TICKS;
      cfg.park_position  <= RST_PARK_POSITION;
      cfg.park_on_close  <= RST_PARK_ON_CLOSE;
      cfg.slow_range     <= RST_SLOW_RANGE;
      cfg.stop_tolerance <= RST_STOP_TOLERANCE;
      cfg.timeout_ms     <= RST_TIMEOUT_MS;
      cfg.home_pos       <= RST_HOME_POS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TURN_TICKS:     cfg.turn_ticks     <= wr_data[15:0];
        REG_PARK_POSITION:  cfg.park_position  <= wr_data[15:0];
        REG_PARK_ON_CLOSE:  cfg.park_on_close  <= wr_data[0];
        REG_SLOW_RANGE:     cfg.slow_range     <= wr_data[15:0];
        REG_STOP_TOLERANCE: cfg.stop_tolerance <= wr_data[15:0];
        REG_TIMEOUT_MS:     cfg.timeout_ms     <= wr_data[31:0];
        REG_HOME_POS:       cfg.home_pos       <= wr_data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/dam_ctrl.sv =====
`timescale 1ns / 1ps

module dam_ctrl
  import dam_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  fsm_t        fsm_state, fsm_state_next;
  logic        move_dir, move_dir_next;
  logic [15:0] target_position, target_position_next;
  logic        parking_flag, parking_flag_next;
  logic [31:0] start_time, start_time_next;
  logic        home_latch, home_latch_next;
  logic [2:0]  drive_levels, drive_levels_next;

  event_t      ev;
  logic        close_req;
  logic        timed_out;
  logic [15:0] arc;
  logic [31:0] elapsed;

  // Hold state; advance once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state       <= ST_IDLE;
      move_dir        <= DIR_CW;
      target_position <= '0;
      parking_flag    <= 1'b0;
      start_time      <= '0;
      home_latch      <= 1'b0;
      drive_levels    <= '0;
    end else if (step) begin
      fsm_state       <= fsm_state_next;
      move_dir        <= move_dir_next;
      target_position <= target_position_next;
      parking_flag    <= parking_flag_next;
      start_time      <= start_time_next;
      home_latch      <= home_latch_next;
      drive_levels    <= drive_levels_next;
    end
  end

  // Apply the command, then step the state machine
  always_comb begin
    fsm_state_next       = fsm_state;
    move_dir_next        = move_dir;
    target_position_next = target_position;
    parking_flag_next    = parking_flag;
    start_time_next      = start_time;
    home_latch_next      = home_latch | item.home_seen;
    drive_levels_next    = drive_levels;
    ev                   = EV_NONE;
    close_req            = 1'b0;

    unique case (item.mode)
      MODE_HOME: begin
        if (!parking_flag) begin
          // shortest way to tick zero
          move_dir_next = (item.position > (cfg.turn_ticks >> 1)) ? DIR_CW : DIR_CCW;
          ev            = EV_HOME;
        end
      end
      MODE_GOTO: begin
        if (!parking_flag) begin
          move_dir_next        = item.goto_dir;
          target_position_next = item.goto_target;
          ev                   = EV_GOTO;
        end
      end
      MODE_ABORT: ev = EV_ABORT;
      MODE_CLOSE: begin
        if (cfg.park_on_close) begin
          parking_flag_next    = 1'b1;
          target_position_next = cfg.park_position;
          ev                   = EV_GOTO;
        end else begin
          close_req = 1'b1;
        end
      end
      default: ;
    endcase

    elapsed   = item.now_ms - start_time;
    timed_out = elapsed > cfg.timeout_ms;
    arc       = ring_dist(item.position, target_position_next, cfg.turn_ticks);

    unique case (fsm_state)
      ST_SEEK: begin
        if (ev == EV_ABORT) begin
          parking_flag_next = 1'b0;
          drive_levels_next = '0;
          fsm_state_next    = ST_IDLE;
        end else if (home_latch_next) begin
          drive_levels_next = '0;
          fsm_state_next    = ST_IDLE;
          home_latch_next   = 1'b0;
        end else if (timed_out) begin
          drive_levels_next = '0;
          fsm_state_next    = ST_FAULT;
        end
      end
      ST_SLEW: begin
        if (ev == EV_ABORT) begin
          parking_flag_next = 1'b0;
          drive_levels_next = '0;
          fsm_state_next    = ST_IDLE;
        end else if (arc < cfg.slow_range) begin
          drive_levels_next = drive_code(move_dir_next, 1'b1);
          fsm_state_next    = ST_APPROACH;
        end else if (timed_out) begin
          drive_levels_next = '0;
          fsm_state_next    = ST_FAULT;
        end
      end
      ST_APPROACH: begin
        if (ev == EV_ABORT) begin
          parking_flag_next = 1'b0;
          drive_levels_next = '0;
          fsm_state_next    = ST_IDLE;
        end else if (arc < cfg.stop_tolerance) begin
          drive_levels_next = '0;
          // park arrival asks the shutter to close
          if (parking_flag_next) begin
            parking_flag_next = 1'b0;
            close_req         = 1'b1;
          end
          fsm_state_next = ST_IDLE;
        end else if (timed_out) begin
          drive_levels_next = '0;
          fsm_state_next    = ST_FAULT;
        end
      end
      default: begin
        // idle, error and unused codes start a motion on home or goto
        if (ev == EV_HOME) begin
          start_time_next   = item.now_ms;
          fsm_state_next    = ST_SEEK;
          drive_levels_next = drive_code(move_dir_next, 1'b0);
        end else if (ev == EV_GOTO) begin
          start_time_next   = item.now_ms;
          fsm_state_next    = ST_SLEW;
          drive_levels_next = drive_code(move_dir_next, 1'b0);
        end
      end
    endcase

    result.drive_cw      = drive_levels_next[0];
    result.drive_ccw     = drive_levels_next[1];
    result.motor_slow    = drive_levels_next[2];
    result.close_request = close_req;
    unique case (fsm_state_next)
      ST_FAULT:                        result.dome_status = STAT_ERROR;
      ST_SEEK, ST_SLEW, ST_APPROACH:   result.dome_status =
                                         move_dir_next ? STAT_CCW : STAT_CW;
      default:                         result.dome_status = STAT_IDLE;
    endcase
  end

endmodule
